>>> src/ael_pkg.sv
// Shared types and character codes for the arithmetic expression lexer.
package ael_pkg;

    // Token kind codes on the result channel
    typedef enum logic [3:0] {
        K_INT     = 4'd0,
        K_ADD     = 4'd1,
        K_SUB     = 4'd2,
        K_MUL     = 4'd3,
        K_DIV     = 4'd4,
        K_MOD     = 4'd5,
        K_LP      = 4'd6,
        K_RP      = 4'd7,
        K_POSTINC = 4'd8,
        K_PREINC  = 4'd9,
        K_POSTDEC = 4'd10,
        K_PREDEC  = 4'd11,
        K_LINEEND = 4'd12,
        K_UNKNOWN = 4'd13,
        K_TOOLONG = 4'd14
    } t_tok_kind;

    // Lookahead state, one-hot
    typedef enum logic [6:0] {
        P_NONE  = 7'b0000001,
        P_INT   = 7'b0000010,
        P_PLUS  = 7'b0000100,
        P_MINUS = 7'b0001000,
        P_PP    = 7'b0010000,
        P_MM    = 7'b0100000,
        P_SKIP  = 7'b1000000
    } t_pend;

    localparam int          VAL_W   = 31;
    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    // One result beat
    typedef struct packed {
        t_tok_kind          kind;
        logic [VAL_W-1:0]   value;
        logic               last;
    } t_tok;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

>>> src/arith_expr_lexer.sv
// Character-in, token-out lexer for a small arithmetic language.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_ch
//  out     | output    | o_out_valid / i_out_stall| o_token_kind, o_int_value, o_last_of_run
//
// One character per cycle: its tokens are decoded in the accept cycle and
// written into a four-entry result queue, so the first token can leave on the
// next cycle. A character gives at most two tokens; the input stalls while the
// queue has fewer than two free entries, so sustained rate is one character per
// cycle while the output drains at least one token per character.
// Reset (synchronous, active low) clears the lookahead state and empties the queue.
module arith_expr_lexer #(
    parameter int MAX_TOKEN_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_token_kind,
    output logic [30:0] o_int_value,
    output logic        o_last_of_run
);
    import ael_pkg::*;

    localparam int         QDEPTH  = 4;
    localparam int         QPTR_W  = $clog2(QDEPTH);
    localparam int         QCNT_W  = $clog2(QDEPTH + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

    // Lookahead state
    t_pend       r_pend, n_pend;
    logic [30:0] r_acc, n_acc;
    logic [7:0]  r_cnt, n_cnt;

    // Result queue
    t_tok              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_qcnt;

    logic        in_acc, out_acc;
    logic        dig;
    logic [3:0]  dval;
    logic [34:0] prod;
    logic        f_ok, c_ok;
    t_tok        f_tok, c_tok, slot0;
    logic [1:0]  push_n;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_qcnt != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_qcnt > QCNT_W'(QDEPTH - 2));

    assign dig  = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign dval = i_ch[3:0];
    // acc*10 + d, compared against the 31-bit ceiling for saturation
    assign prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {31'b0, dval};

    // Decode: flushed pending token first, then the token of the character
    always_comb begin
        logic go_fresh;
        go_fresh = 1'b0;
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        f_ok     = 1'b0;
        c_ok     = 1'b0;
        f_tok    = '{kind: K_INT, value: '0, last: 1'b0};
        c_tok    = '{kind: K_UNKNOWN, value: '0, last: 1'b1};

        case (r_pend)
            P_INT: begin
                if (dig) begin
                    if (r_cnt >= MAX_LEN) begin
                        n_pend     = P_SKIP;
                        n_acc      = '0;
                        n_cnt      = '0;
                        f_ok       = 1'b1;
                        f_tok.kind = K_TOOLONG;
                    end else begin
                        n_acc = (prod > {4'b0, VAL_MAX}) ? VAL_MAX : prod[30:0];
                        n_cnt = r_cnt + 8'd1;
                    end
                end else begin
                    f_ok        = 1'b1;
                    f_tok.kind  = K_INT;
                    f_tok.value = r_acc;
                    go_fresh    = 1'b1;
                end
            end
            P_SKIP: begin
                go_fresh = !dig;
            end
            P_PLUS: begin
                if (i_ch == CH_PLUS) begin
                    n_pend = P_PP;
                end else begin
                    f_ok       = 1'b1;
                    f_tok.kind = K_ADD;
                    go_fresh   = 1'b1;
                end
            end
            P_MINUS: begin
                if (i_ch == CH_MINUS) begin
                    n_pend = P_MM;
                end else begin
                    f_ok       = 1'b1;
                    f_tok.kind = K_SUB;
                    go_fresh   = 1'b1;
                end
            end
            P_PP: begin
                f_ok       = 1'b1;
                f_tok.kind = dig ? K_PREINC : K_POSTINC;
                go_fresh   = 1'b1;
            end
            P_MM: begin
                f_ok       = 1'b1;
                f_tok.kind = dig ? K_PREDEC : K_POSTDEC;
                go_fresh   = 1'b1;
            end
            default: begin
                go_fresh = 1'b1;
            end
        endcase

        // Character handled with nothing pending
        if (go_fresh) begin
            n_pend = P_NONE;
            n_acc  = '0;
            n_cnt  = '0;
            if (dig) begin
                n_pend = P_INT;
                n_acc  = {27'b0, dval};
                n_cnt  = 8'd1;
            end else begin
                case (i_ch)
                    CH_PLUS:  n_pend = P_PLUS;
                    CH_MINUS: n_pend = P_MINUS;
                    CH_MUL: begin
                        c_ok = 1'b1; c_tok.kind = K_MUL;
                    end
                    CH_DIV: begin
                        c_ok = 1'b1; c_tok.kind = K_DIV;
                    end
                    CH_MOD: begin
                        c_ok = 1'b1; c_tok.kind = K_MOD;
                    end
                    CH_LP: begin
                        c_ok = 1'b1; c_tok.kind = K_LP;
                    end
                    CH_RP: begin
                        c_ok = 1'b1; c_tok.kind = K_RP;
                    end
                    CH_LF: begin
                        c_ok = 1'b1; c_tok.kind = K_LINEEND;
                    end
                    CH_SPACE, CH_TAB, CH_NUL: begin
                        c_ok = 1'b0;
                    end
                    default: begin
                        c_ok = 1'b1; c_tok.kind = K_UNKNOWN;
                    end
                endcase
            end
        end

        f_tok.last = !c_ok;
        slot0      = f_ok ? f_tok : c_tok;
        push_n     = {1'b0, f_ok} + {1'b0, c_ok};
    end

    // Lookahead state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= P_NONE;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (in_acc) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    // Queue storage: up to two beats written per accepted character
    always_ff @(posedge i_clk) begin
        if (in_acc && (push_n != 2'd0)) begin
            r_q[r_wr] <= slot0;
        end
        if (in_acc && (push_n == 2'd2)) begin
            r_q[r_wr + QPTR_W'(1)] <= c_tok;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            if (in_acc) begin
                r_wr <= r_wr + QPTR_W'(push_n);
            end
            if (out_acc) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_qcnt <= r_qcnt + (in_acc ? QCNT_W'(push_n) : '0) - QCNT_W'(out_acc);
        end
    end

    // Head of queue drives the result beat
    assign o_token_kind  = r_q[r_rd].kind;
    assign o_int_value   = r_q[r_rd].value;
    assign o_last_of_run = r_q[r_rd].last;

endmodule
